// ===== rtl/c20_pkg.sv =====
// Shared types, constants and helper functions for the ChaCha20 keystream XOR block.
// Used by c20_block_gen and chacha20_keystream_xor; no dependencies.
package c20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int BLOCK_BYTES       = 64;
  localparam int POS_W             = $clog2(BLOCK_BYTES);
  localparam int CFG_IDX_W         = 3;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0_7    = 3'd0,
    CFG_KEY_8_15   = 3'd1,
    CFG_KEY_16_23  = 3'd2,
    CFG_KEY_24_31  = 3'd3,
    CFG_NONCE_0_7  = 3'd4,
    CFG_NONCE_8_11 = 3'd5,
    CFG_INIT_CTR   = 3'd6
  } cfg_idx_t;

  typedef logic [15:0][31:0] words_t;

  typedef enum logic [2:0] {
    GEN_IDLE  = 3'b001,
    GEN_ROUND = 3'b010,
    GEN_FEED  = 3'b100
  } gen_state_t;

  typedef struct packed {
    logic start;
    logic abort;
    logic consume;
  } gen_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_stat_t;

  function automatic words_t init_words(input logic [255:0] key, input logic [95:0] nonce,
                                        input logic [31:0] ctr);
    words_t w;
    w[0] = SIGMA0;
    w[1] = SIGMA1;
    w[2] = SIGMA2;
    w[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      w[4+i] = key[32*i +: 32];
    end
    w[12] = ctr;
    w[13] = nonce[31:0];
    w[14] = nonce[63:32];
    w[15] = nonce[95:64];
    return w;
  endfunction

  // Rotate each row of four words left by its own amount.
  function automatic words_t row_rotl(input words_t w, input logic [3:0][1:0] amt);
    words_t     o;
    logic [1:0] src;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        src = 2'(j) + amt[r];
        o[4*r+j] = w[{2'(r), src}];
      end
    end
    return o;
  endfunction

endpackage

// ===== rtl/chacha20_keystream_xor.sv =====
// ChaCha20 (IETF) keystream XOR, one byte per word on a stream interface.
// Channels: s_* input bytes with tlast marking a message's last byte,
// m_* result bytes with the same tlast, cfg_* register writes
// (0..3 key, 4..5 nonce, 6 initial block counter; cfg_ready is always high).
// Latency: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while a keystream block is on hand and the
// receiver is not stalling. A new 64-byte block is made in steps: a load of
// the state, then the single add/xor/rotate unit doing one quarter-round
// line per cycle, then the feed-forward of the 16 words through the same
// adder; s_tready is low during that time.
// A block is made as soon as the previous one is used up, so the wait often
// overlaps the sender's gaps. Any register write, and every tlast, restarts
// at the initial counter and recomputes the block.
// Reset clears the key, nonce and counter registers to zero and starts the first block at once.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken.
// Depends on c20_pkg and c20_block_gen.
module chacha20_keystream_xor #(
  parameter int DOUBLE_ROUNDS = c20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // [7:0] data_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,    // [7:0] result_byte
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [c20_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam logic [c20_pkg::POS_W-1:0] PosLast = c20_pkg::POS_W'(c20_pkg::BLOCK_BYTES - 1);

  logic [3:0][63:0]            key_reg;
  logic [63:0]                 nonce_lo;
  logic [31:0]                 nonce_hi;
  logic [31:0]                 init_ctr;
  logic [31:0]                 ctr_load;
  logic [31:0]                 block_counter;
  logic [c20_pkg::POS_W-1:0]   byte_pos;
  logic                        ks_valid;
  logic                        cfg_hit;
  logic                        s_fire;
  logic [7:0]                  ks_byte;
  c20_pkg::gen_ctrl_t          gen_ctrl;
  c20_pkg::gen_stat_t          gen_stat;

  assign cfg_ready = 1'b1;
  assign s_tready  = ks_valid && (!m_tvalid || m_tready);
  assign s_fire    = s_tvalid && s_tready;

  always_comb begin
    unique case (c20_pkg::cfg_idx_t'(cfg_index))
      c20_pkg::CFG_KEY_0_7, c20_pkg::CFG_KEY_8_15, c20_pkg::CFG_KEY_16_23,
      c20_pkg::CFG_KEY_24_31, c20_pkg::CFG_NONCE_0_7, c20_pkg::CFG_NONCE_8_11,
      c20_pkg::CFG_INIT_CTR: cfg_hit = cfg_valid && cfg_ready;
      default:               cfg_hit = 1'b0;
    endcase
  end

  // a counter write applies to the block that follows immediately
  assign ctr_load = (c20_pkg::cfg_idx_t'(cfg_index) == c20_pkg::CFG_INIT_CTR) ?
                    cfg_data[31:0] : init_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg  <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
      init_ctr <= '0;
    end else if (cfg_hit) begin
      unique case (c20_pkg::cfg_idx_t'(cfg_index))
        c20_pkg::CFG_KEY_0_7:    key_reg[0] <= cfg_data;
        c20_pkg::CFG_KEY_8_15:   key_reg[1] <= cfg_data;
        c20_pkg::CFG_KEY_16_23:  key_reg[2] <= cfg_data;
        c20_pkg::CFG_KEY_24_31:  key_reg[3] <= cfg_data;
        c20_pkg::CFG_NONCE_0_7:  nonce_lo   <= cfg_data;
        c20_pkg::CFG_NONCE_8_11: nonce_hi   <= cfg_data[31:0];
        c20_pkg::CFG_INIT_CTR:   init_ctr   <= cfg_data[31:0];
        default:                 init_ctr   <= init_ctr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      ks_valid      <= 1'b0;
      block_counter <= '0;
    end else if (cfg_hit) begin
      byte_pos      <= '0;
      ks_valid      <= 1'b0;
      block_counter <= ctr_load;
    end else if (s_fire) begin
      if (s_tlast) begin
        byte_pos      <= '0;
        ks_valid      <= 1'b0;
        block_counter <= init_ctr;
      end else if (byte_pos == PosLast) begin
        byte_pos      <= '0;
        ks_valid      <= 1'b0;
        block_counter <= block_counter + 32'd1;
      end else begin
        byte_pos <= byte_pos + c20_pkg::POS_W'(1);
      end
    end else if (gen_stat.done) begin
      ks_valid <= 1'b1;
    end
  end

  assign gen_ctrl.start   = !ks_valid && !gen_stat.busy && !cfg_hit;
  assign gen_ctrl.abort   = cfg_hit;
  assign gen_ctrl.consume = s_fire;

  c20_block_gen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_gen (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (gen_ctrl),
    .stat    (gen_stat),
    .key     (key_reg),
    .nonce   ({nonce_hi, nonce_lo}),
    .counter (block_counter),
    .ks_byte (ks_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= s_tdata ^ ks_byte;
      m_tlast <= s_tlast;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_tvalid)
    else $error("accepted word produced no result");

  a_no_accept_while_gen: assert property (@(posedge clk) disable iff (rst)
    gen_stat.busy |-> !s_tready)
    else $error("input accepted while keystream block is being computed");

  a_done_when_empty: assert property (@(posedge clk) disable iff (rst)
    gen_stat.done |-> !ks_valid)
    else $error("block finished while a keystream block was still held");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_tlast && (byte_pos == PosLast) && !cfg_hit) |=>
      (block_counter == $past(block_counter) + 32'd1))
    else $error("block counter did not advance at block end");
`endif

endmodule

// ===== rtl/c20_arx_unit.sv =====
// Shared add / xor / rotate unit: one line of a quarter-round per use.
// Depends on nothing; instantiated by c20_block_gen.
module c20_arx_unit (
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] z,
  input  logic [1:0]  step,
  output logic [31:0] sum,
  output logic [31:0] mix
);

  logic [31:0] t;

  assign sum = x + y;
  assign t   = z ^ sum;

  always_comb begin
    unique case (step)
      2'd0: mix = {t[15:0], t[31:16]};
      2'd1: mix = {t[19:0], t[31:20]};
      2'd2: mix = {t[23:0], t[31:24]};
      2'd3: mix = {t[24:0], t[31:25]};
    endcase
  end

endmodule

// ===== rtl/c20_block_gen.sv =====
// Keystream block generator: 16-word state register, round sequencer and feed-forward.
// Depends on c20_pkg and c20_arx_unit.
module c20_block_gen #(
  parameter int DOUBLE_ROUNDS = c20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  c20_pkg::gen_ctrl_t ctrl,
  output c20_pkg::gen_stat_t stat,
  input  logic [255:0]       key,
  input  logic [95:0]        nonce,
  input  logic [31:0]        counter,
  output logic [7:0]         ks_byte
);

  localparam int RndW = $clog2(2 * DOUBLE_ROUNDS);
  localparam logic [RndW-1:0] RndLast = RndW'(2 * DOUBLE_ROUNDS - 1);

  c20_pkg::gen_state_t state;
  c20_pkg::words_t     words;
  c20_pkg::words_t     init_w;
  c20_pkg::words_t     upd;
  c20_pkg::words_t     round_next;
  logic [3:0][1:0]     amt;
  logic [1:0]          step;
  logic [1:0]          qr;
  logic [RndW-1:0]     rnd;
  logic [3:0]          ff_idx;
  logic [31:0]         x, y, z, sum, mix;

  assign init_w = c20_pkg::init_words(key, nonce, counter);

  // Quarter-round always works on column 0; rows are rotated between uses.
  always_comb begin
    if (state == c20_pkg::GEN_FEED) begin
      x = words[0];
      y = init_w[ff_idx];
      z = words[0];
    end else if (!step[0]) begin
      x = words[0];
      y = words[4];
      z = words[12];
    end else begin
      x = words[8];
      y = words[12];
      z = words[4];
    end
  end

  c20_arx_unit u_arx (
    .x    (x),
    .y    (y),
    .z    (z),
    .step (step),
    .sum  (sum),
    .mix  (mix)
  );

  // After the last quarter-round of a column round the rows are diagonalized,
  // after a diagonal round they are put back.
  always_comb begin
    logic [1:0] rr;
    logic [1:0] extra;
    upd = words;
    if (!step[0]) begin
      upd[0]  = sum;
      upd[12] = mix;
    end else begin
      upd[8]  = sum;
      upd[4]  = mix;
    end
    for (int r = 0; r < 4; r++) begin
      rr     = 2'(r);
      extra  = (qr == 2'd3) ? (rnd[0] ? (2'd0 - rr) : rr) : 2'd0;
      amt[r] = (step == 2'd3) ? (2'd1 + extra) : 2'd0;
    end
    round_next = c20_pkg::row_rotl(upd, amt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= c20_pkg::GEN_IDLE;
      step   <= '0;
      qr     <= '0;
      rnd    <= '0;
      ff_idx <= '0;
    end else if (ctrl.abort) begin
      state <= c20_pkg::GEN_IDLE;
    end else begin
      unique case (state)
        c20_pkg::GEN_IDLE: begin
          if (ctrl.start) begin
            state <= c20_pkg::GEN_ROUND;
            step  <= '0;
            qr    <= '0;
            rnd   <= '0;
          end
        end
        c20_pkg::GEN_ROUND: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            qr <= qr + 2'd1;
            if (qr == 2'd3) begin
              rnd <= rnd + RndW'(1);
              if (rnd == RndLast) begin
                state  <= c20_pkg::GEN_FEED;
                ff_idx <= '0;
              end
            end
          end
        end
        c20_pkg::GEN_FEED: begin
          ff_idx <= ff_idx + 4'd1;
          if (ff_idx == 4'd15) begin
            state <= c20_pkg::GEN_IDLE;
          end
        end
        default: state <= c20_pkg::GEN_IDLE;
      endcase
    end
  end

  // Idle: load or shift out one keystream byte. Round: one quarter-round line. Feed: word rotate with add.
  always_ff @(posedge clk) begin
    unique case (state)
      c20_pkg::GEN_IDLE: begin
        if (ctrl.start) begin
          words <= init_w;
        end else if (ctrl.consume) begin
          words <= c20_pkg::words_t'(words >> 8);
        end
      end
      c20_pkg::GEN_ROUND: words <= round_next;
      c20_pkg::GEN_FEED:  words <= {sum, words[15:1]};
      default:            words <= words;
    endcase
  end

  assign stat.busy = (state != c20_pkg::GEN_IDLE);
  assign stat.done = (state == c20_pkg::GEN_FEED) && (ff_idx == 4'd15);
  assign ks_byte   = words[0][7:0];

endmodule
